### rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared definitions for the infix to prefix converter
// Character codes, sizes, sequencer states and the two precedence tables.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

   // longest expression kept; later characters are dropped
   localparam int MAX_LEN = 32;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = ADDR_W + 1;

   // character codes
   localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
   localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
   localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
   localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
   localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
   localparam logic [7:0] CH_PCT    = 8'h25;  // '%'
   localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
   localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
   localparam logic [7:0] CH_LPAR   = 8'h28;  // '('
   localparam logic [7:0] CH_RPAR   = 8'h29;  // ')'

   // precedences carry an offset of one so they stay unsigned;
   // the empty stack ranks zero
   localparam logic [3:0] PREC_EMPTY = 4'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_EVAL,
      ST_POP_LOAD,
      ST_NEXT_LOAD,
      ST_DRAIN,
      ST_DRAIN_LOAD,
      ST_OUT_INIT,
      ST_OUT_READ,
      ST_OUT_WAIT
   } state_type;

   // precedence of a character sitting on the stack
   function automatic logic [3:0] stack_prec(input logic [7:0] c);
      logic [3:0] p;
      case (c) inside
         CH_PLUS, CH_MINUS:          p = 4'd2;
         CH_STAR, CH_SLASH, CH_PCT:  p = 4'd4;
         CH_CARET, CH_DOLLAR:        p = 4'd7;
         CH_RPAR:                    p = 4'd1;
         CH_HASH:                    p = 4'd0;
         default:                    p = 4'd9;
      endcase
      return p;
   endfunction

   // precedence of an incoming character
   function automatic logic [3:0] input_prec(input logic [7:0] c);
      logic [3:0] p;
      case (c) inside
         CH_PLUS, CH_MINUS:          p = 4'd3;
         CH_STAR, CH_SLASH, CH_PCT:  p = 4'd5;
         CH_CARET, CH_DOLLAR:        p = 4'd6;
         CH_LPAR:                    p = 4'd1;
         CH_RPAR:                    p = 4'd10;
         default:                    p = 4'd8;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

### rtl/infix_to_prefix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_prefix_converter: infix expression to prefix expression
// Stores characters, runs a reverse scan with an operator stack and
// streams the prefix expression out one character per beat.
// ----------------------------------------------------------------------------
// Each request beat is one character; the beat with last_in set closes the
// expression. req_ready stays high while loading, so a character is taken on
// every beat. After the last character the block drops req_ready and runs
// the conversion on a small sequencer around three memories with one write
// port and one registered read port each (character store, operator stack,
// result store): a scanned character passes the scan, fetch and evaluate
// states, each popped operator adds a pop-load state, a discarded parenthesis
// pair a next-load state, and the drain a drain and a drain-load state per
// stacked entry; each response beat passes a read and a wait state and holds
// while rsp_ready is low. Characters beyond MAX_LEN are dropped and every
// response beat of that expression shows rsp_overflow. An expression that
// yields no characters, such as "()", gives no response beat.
`default_nettype none

module infix_to_prefix_converter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_last_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_last_out,
   output logic            rsp_overflow
);
   import itp_pkg::*;

   // memories
   logic [7:0] char_mem [MAX_LEN];
   logic [7:0] stk_mem  [MAX_LEN];
   logic [7:0] res_mem  [MAX_LEN];

   // registers
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] rc_ff, rc_in;
   logic [ADDR_W-1:0] out_idx_ff, out_idx_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       cur_ff, cur_in;
   logic [7:0]       top_char_ff, top_char_in;
   logic [7:0]       char_rdata_ff, stk_rdata_ff, res_rdata_ff;

   // memory ports
   logic              char_we, stk_we, res_we;
   logic [ADDR_W-1:0] char_waddr, char_raddr, stk_waddr, stk_raddr, res_waddr;
   logic [7:0]        char_wdata, stk_wdata, res_wdata;

   // precedence compare
   logic [3:0] top_prec, cur_prec;
   logic       req_beat;

   assign top_prec = (top_ff == '0) ? PREC_EMPTY : stack_prec(top_char_ff);
   assign cur_prec = input_prec(cur_ff);
   assign req_beat = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
         rc_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         rc_ff    <= rc_in;
         ovf_ff   <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      out_idx_ff  <= out_idx_in;
      cur_ff      <= cur_in;
      top_char_ff <= top_char_in;
   end

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (char_we) char_mem[char_waddr] <= char_wdata;
      char_rdata_ff <= char_mem[char_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (res_we) res_mem[res_waddr] <= res_wdata;
      res_rdata_ff <= res_mem[out_idx_ff];
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      top_in      = top_ff;
      rc_in       = rc_ff;
      out_idx_in  = out_idx_ff;
      ovf_in      = ovf_ff;
      cur_in      = cur_ff;
      top_char_in = top_char_ff;

      char_we    = 1'b0;
      char_waddr = count_ff[ADDR_W-1:0];
      char_wdata = req_char_in;
      char_raddr = ADDR_W'(scan_ff - 1'b1);
      stk_we     = 1'b0;
      stk_waddr  = top_ff[ADDR_W-1:0];
      stk_wdata  = cur_ff;
      stk_raddr  = ADDR_W'(top_ff - 2'd2);
      res_we     = 1'b0;
      res_waddr  = rc_ff[ADDR_W-1:0];
      res_wdata  = top_char_ff;

      req_ready  = 1'b0;
      rsp_valid  = 1'b0;

      unique case (state_ff)
         // load characters
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_beat) begin
               if (count_ff < CNT_W'(MAX_LEN)) begin
                  char_we  = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  scan_in  = count_in;
                  top_in   = '0;
                  rc_in    = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         // next character from the end, read issued here
         ST_SCAN: begin
            if (scan_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in  = scan_ff - 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cur_in   = char_rdata_ff;
            state_in = ST_EVAL;
         end
         // pop, push or discard a matched pair
         ST_EVAL: begin
            if (top_ff != '0 && top_prec > cur_prec) begin
               if (rc_ff < CNT_W'(MAX_LEN)) begin
                  res_we = 1'b1;
                  rc_in  = rc_ff + 1'b1;
               end
               top_in   = top_ff - 1'b1;
               state_in = ST_POP_LOAD;
            end else if (top_prec != cur_prec) begin
               if (top_ff < CNT_W'(MAX_LEN)) begin
                  stk_we      = 1'b1;
                  top_in      = top_ff + 1'b1;
                  top_char_in = cur_ff;
               end
               state_in = ST_SCAN;
            end else if (top_ff != '0) begin
               top_in   = top_ff - 1'b1;
               state_in = ST_NEXT_LOAD;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_POP_LOAD: begin
            top_char_in = stk_rdata_ff;
            state_in    = ST_EVAL;
         end
         ST_NEXT_LOAD: begin
            top_char_in = stk_rdata_ff;
            state_in    = ST_SCAN;
         end
         // empty the stack into the result store
         ST_DRAIN: begin
            if (top_ff == '0) begin
               state_in = ST_OUT_INIT;
            end else begin
               if (rc_ff < CNT_W'(MAX_LEN)) begin
                  res_we = 1'b1;
                  rc_in  = rc_ff + 1'b1;
               end
               top_in   = top_ff - 1'b1;
               state_in = ST_DRAIN_LOAD;
            end
         end
         ST_DRAIN_LOAD: begin
            top_char_in = stk_rdata_ff;
            state_in    = ST_DRAIN;
         end
         // result store is read back to front
         ST_OUT_INIT: begin
            if (rc_ff == '0) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               out_idx_in = ADDR_W'(rc_ff - 1'b1);
               state_in   = ST_OUT_READ;
            end
         end
         ST_OUT_READ: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (out_idx_ff == '0) begin
                  count_in = '0;
                  top_in   = '0;
                  rc_in    = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff - 1'b1;
                  state_in   = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response payload
   assign rsp_char_out = res_rdata_ff;
   assign rsp_last_out = (out_idx_ff == '0);
   assign rsp_overflow = ovf_ff;

endmodule

`default_nettype wire
